// ===== rtl/core/dmux_pkg.sv =====
package dmux_pkg;

    localparam int NUM_CHANNELS = 32;
    localparam int CH_W         = $clog2(NUM_CHANNELS);
    localparam int OFFSET_W     = 12;
    localparam int WDATA_W      = 64;
    localparam int SIZE_W       = 4;
    localparam int LINE_W       = 7;
    localparam int BYTE_W       = 8;
    localparam int MAX_BYTES    = WDATA_W / BYTE_W;
    localparam int BSEL_W       = $clog2(MAX_BYTES);
    localparam int SRC_W        = 6;

    localparam int IN_TDATA_W   = 88;
    localparam int OUT_TDATA_W  = 40;

    // channel config byte layout
    localparam int CFG_ENABLE_BIT  = 7;
    localparam int CFG_TRIGGER_BIT = 6;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_LINE  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_type;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

// ===== rtl/core/dmux_ctrl.sv =====
module dmux_ctrl
    import dmux_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // result register must be free before state is updated
                if (out_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/core/dmux_dp.sv =====
module dmux_dp
    import dmux_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [1:0]            i_req_type,
    input  logic [OFFSET_W-1:0]   i_offset,
    input  logic [WDATA_W-1:0]    i_write_data,
    input  logic [SIZE_W-1:0]     i_access_size,
    input  logic [LINE_W-1:0]     i_request_line,
    input  logic                  i_request_level,
    output logic [BYTE_W-1:0]     o_read_data,
    output logic [NUM_CHANNELS-1:0] o_channel_requests
);

    // captured transaction
    t_req_type             r_req_type;
    logic [OFFSET_W-1:0]   r_offset;
    logic [WDATA_W-1:0]    r_write_data;
    logic [SIZE_W-1:0]     r_access_size;
    logic [LINE_W-1:0]     r_request_line;
    logic                  r_request_level;

    logic [BYTE_W-1:0]       r_cfg [NUM_CHANNELS];
    logic [BYTE_W-1:0]       n_cfg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_levels, n_levels;
    logic [BYTE_W-1:0]       r_read_data, n_read_data;
    logic [NUM_CHANNELS-1:0] r_chan_req;

    logic                  off_in_range;
    logic                  line_in_range;
    logic [SIZE_W-1:0]     size_c;
    logic [CH_W:0]         rel [NUM_CHANNELS];

    assign off_in_range  = (r_offset[OFFSET_W-1:CH_W] == '0);
    assign line_in_range = (r_request_line[LINE_W-1:SRC_W] == '0);
    assign size_c        = (r_access_size > SIZE_W'(MAX_BYTES)) ?
                           SIZE_W'(MAX_BYTES) : r_access_size;

    always_comb begin
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            rel[ch]   = {1'b0, CH_W'(ch)} - {1'b0, r_offset[CH_W-1:0]};
            n_cfg[ch] = r_cfg[ch];
            // channel at or above the offset and inside the access size
            if (r_req_type == REQ_WRITE && off_in_range && !rel[ch][CH_W] &&
                ({1'b0, rel[ch][CH_W-1:0]} < (CH_W+1)'(size_c))) begin
                n_cfg[ch] = r_write_data[{rel[ch][BSEL_W-1:0], 3'b000} +: BYTE_W];
            end
        end
    end

    always_comb begin
        n_levels = r_levels;
        if (r_req_type == REQ_LINE && line_in_range) begin
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                if (r_cfg[ch][CFG_ENABLE_BIT] &&
                    r_cfg[ch][SRC_W-1:0] == r_request_line[SRC_W-1:0]) begin
                    n_levels[ch] = r_request_level;
                end
            end
        end
    end

    always_comb begin
        n_read_data = '0;
        if (r_req_type == REQ_READ && off_in_range) begin
            n_read_data = r_cfg[r_offset[CH_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type      <= t_req_type'(i_req_type);
            r_offset        <= i_offset;
            r_write_data    <= i_write_data;
            r_access_size   <= i_access_size;
            r_request_line  <= i_request_line;
            r_request_level <= i_request_level;
        end
        if (i_cmd.exec) begin
            r_read_data <= n_read_data;
            r_chan_req  <= n_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= '0;
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                r_cfg[ch] <= '0;
            end
        end else if (i_cmd.exec) begin
            r_levels <= n_levels;
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                r_cfg[ch] <= n_cfg[ch];
            end
        end
    end

    assign o_read_data        = r_read_data;
    assign o_channel_requests = r_chan_req;

endmodule

// ===== rtl/core/dma_request_mux.sv =====
// dma request multiplexer: 32 byte-wide channel config registers and request routing
// an input transaction is captured, then executed into the output register once that register is free
// a new transaction is accepted only after the previous one has executed, set by the capture/execute controller
// the input side is free again while a result waits in the output register
// reset (synchronous, active low) clears all channel configs, request levels
// and the handshake state; no result is pending after reset
module dma_request_mux
    import dmux_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [11:0] offset, [75:12] write_data, [79:76] access_size,
    // [86:80] request_line, [87] request_level
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]             s_axis_tuser,
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] read_data, [39:8] channel_requests
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_dp_cmd                 cmd;
    logic [BYTE_W-1:0]       read_data;
    logic [NUM_CHANNELS-1:0] channel_requests;

    // sequencing: accept, execute, hand result to output register
    dmux_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    // config registers, write byte lanes, per channel source compare
    dmux_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_req_type         (s_axis_tuser),
        .i_offset           (s_axis_tdata[11:0]),
        .i_write_data       (s_axis_tdata[75:12]),
        .i_access_size      (s_axis_tdata[79:76]),
        .i_request_line     (s_axis_tdata[86:80]),
        .i_request_level    (s_axis_tdata[87]),
        .o_read_data        (read_data),
        .o_channel_requests (channel_requests)
    );

    // result packing, read byte in the low bits
    assign m_axis_tdata = {channel_requests, read_data};

endmodule
